FILE: sv/wlsc_pkg.sv
// shared types, constants and compare helpers of the wolfe line search controller
`timescale 1ns / 1ps
`default_nettype none
package wlsc_pkg;

    // data and working widths
    localparam int DATA_W  = 64;
    localparam int MAN_W   = 108;
    localparam int LZ_W    = 7;
    localparam int EXP_W   = 14;
    localparam int ADDR_W  = 6;
    localparam int IDX_W   = 3;
    localparam int REG_COUNT = 6;

    // binary64 constants
    localparam logic [63:0] FP_ONE  = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] FP_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] FP_QNAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] FP_QBIT = 64'h0008_0000_0000_0000;

    // result status codes
    localparam logic [1:0] STATUS_TRY    = 2'd0;
    localparam logic [1:0] STATUS_DONE   = 2'd1;
    localparam logic [1:0] STATUS_FAILED = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MIN_STEP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_STEP  = 3'd1;
    localparam logic [IDX_W-1:0] REG_DEC_TOL   = 3'd2;
    localparam logic [IDX_W-1:0] REG_CURV      = 3'd3;
    localparam logic [IDX_W-1:0] REG_GROW      = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHRINK    = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE, PH_SEARCH, PH_ACCEPT, PH_FAIL
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BOUND_MUL1, ST_BOUND_MUL2, ST_BOUND_ADD, ST_DECREASE,
        ST_CURV_MUL, ST_CURVATURE, ST_STEP_MUL, ST_CHECK, ST_OUTPUT
    } t_state;

    typedef enum logic [2:0] {
        FS_IDLE, FS_MUL, FS_ADD, FS_NORM, FS_ROUND
    } t_fpu_state;

    typedef enum logic {
        FOP_MUL, FOP_ADD
    } t_fpu_op;

    typedef struct packed {
        logic    start;
        t_fpu_op op;
    } t_fpu_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_fpu_stat;

    // not-a-number test
    function automatic logic fp_is_nan(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    endfunction

    // ordered less-than, false when either side is nan
    function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
        logic res;
        res = 1'b0;
        priority if (fp_is_nan(a) || fp_is_nan(b)) begin
            res = 1'b0;
        end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
            res = 1'b0;
        end else if (a[63] != b[63]) begin
            res = a[63];
        end else if (!a[63]) begin
            res = (a[62:0] < b[62:0]);
        end else begin
            res = (a[62:0] > b[62:0]);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: sv/wlsc_req_if.sv
// request channel: start or trial item with energy and slope
`timescale 1ns / 1ps
`default_nettype none
interface wlsc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] energy;
    logic [63:0] slope;

    modport source (output valid, req_type, energy, slope, input ready);
    modport sink   (input valid, req_type, energy, slope, output ready);
endinterface
`default_nettype wire

FILE: sv/wlsc_rsp_if.sv
// response channel: status and current step
`timescale 1ns / 1ps
`default_nettype none
interface wlsc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] step;

    modport source (output valid, status, step, input ready);
    modport sink   (input valid, status, step, output ready);
endinterface
`default_nettype wire

FILE: sv/wolfe_line_search_controller_top.sv
// top level: strong wolfe step controller with apb registers and shared fpu
// a start item passes through the check and output states before its result is registered
// a trial item runs up to five fpu operations in turn, each multiplication forming four
// 27x27 partial products on one multiplier; a special operand ends an operation at issue
// without the datapath states; a trial outside a search goes straight to the output state
// one item at a time; a new item is taken while the last result waits
// synchronous active-low reset clears registers, step and phase to idle
`timescale 1ns / 1ps
`default_nettype none
module wolfe_line_search_controller_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    wlsc_req_if.sink                           i_req,
    wlsc_rsp_if.source                         o_rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wlsc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [63:0]                   pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready
);

    logic [63:0]          r_cfg [wlsc_pkg::REG_COUNT];
    wlsc_pkg::t_state     r_state, n_state;
    wlsc_pkg::t_phase     r_phase;
    logic [63:0]          r_start_energy, r_start_slope, r_step;
    logic [63:0]          r_energy, r_slope, r_tmp;
    logic                 r_req_type;
    logic                 r_grow_sel;
    logic                 r_issued;
    logic [1:0]           r_status;
    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [63:0]          r_out_step;

    wlsc_pkg::t_fpu_ctl   fpu_ctl;
    wlsc_pkg::t_fpu_stat  fpu_stat;
    logic [63:0]          fpu_a, fpu_b, fpu_res;

    logic [wlsc_pkg::IDX_W-1:0] cfg_idx;
    logic cfg_wr, in_fire, out_load, op_state;
    logic decrease_fail, curv_grow, curv_shrink, check_fail;

    // apb register file
    assign cfg_idx = paddr[wlsc_pkg::ADDR_W-1:wlsc_pkg::ADDR_W-wlsc_pkg::IDX_W];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = (cfg_idx < wlsc_pkg::IDX_W'(wlsc_pkg::REG_COUNT)) ? r_cfg[cfg_idx] : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wlsc_pkg::REG_COUNT; i++) r_cfg[i] <= 64'd0;
        end else if (cfg_wr && (cfg_idx < wlsc_pkg::IDX_W'(wlsc_pkg::REG_COUNT))) begin
            r_cfg[cfg_idx] <= pwdata;
        end
    end

    // shared arithmetic unit
    wlsc_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (fpu_ctl),
        .i_a      (fpu_a),
        .i_b      (fpu_b),
        .o_stat   (fpu_stat),
        .o_result (fpu_res)
    );

    // tests on stored values
    always_comb begin
        decrease_fail = (r_energy[62:52] == 11'h7FF) || wlsc_pkg::fp_lt(r_tmp, r_energy);
        curv_grow     = wlsc_pkg::fp_lt(r_slope, r_tmp);
        curv_shrink   = wlsc_pkg::fp_lt({~r_tmp[63], r_tmp[62:0]}, r_slope);
        check_fail    = wlsc_pkg::fp_lt(wlsc_pkg::FP_ZERO, r_start_slope)
                     || wlsc_pkg::fp_lt(r_step, r_cfg[wlsc_pkg::REG_MIN_STEP])
                     || wlsc_pkg::fp_lt(r_cfg[wlsc_pkg::REG_MAX_STEP], r_step);
    end

    assign in_fire  = i_req.valid && i_req.ready;
    assign out_load = (r_state == wlsc_pkg::ST_OUTPUT) && (!r_out_valid || o_rsp.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wlsc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    priority if (!i_req.req_type) n_state = wlsc_pkg::ST_CHECK;
                    else if (r_phase != wlsc_pkg::PH_SEARCH) n_state = wlsc_pkg::ST_OUTPUT;
                    else n_state = wlsc_pkg::ST_BOUND_MUL1;
                end
            end
            wlsc_pkg::ST_BOUND_MUL1: if (fpu_stat.done) n_state = wlsc_pkg::ST_BOUND_MUL2;
            wlsc_pkg::ST_BOUND_MUL2: if (fpu_stat.done) n_state = wlsc_pkg::ST_BOUND_ADD;
            wlsc_pkg::ST_BOUND_ADD:  if (fpu_stat.done) n_state = wlsc_pkg::ST_DECREASE;
            wlsc_pkg::ST_DECREASE: begin
                n_state = decrease_fail ? wlsc_pkg::ST_STEP_MUL : wlsc_pkg::ST_CURV_MUL;
            end
            wlsc_pkg::ST_CURV_MUL:   if (fpu_stat.done) n_state = wlsc_pkg::ST_CURVATURE;
            wlsc_pkg::ST_CURVATURE: begin
                n_state = (curv_grow || curv_shrink) ? wlsc_pkg::ST_STEP_MUL
                                                     : wlsc_pkg::ST_OUTPUT;
            end
            wlsc_pkg::ST_STEP_MUL:   if (fpu_stat.done) n_state = wlsc_pkg::ST_CHECK;
            wlsc_pkg::ST_CHECK:      n_state = wlsc_pkg::ST_OUTPUT;
            wlsc_pkg::ST_OUTPUT:     if (out_load) n_state = wlsc_pkg::ST_IDLE;
            default:                 n_state = wlsc_pkg::ST_IDLE;
        endcase
    end

    // outputs: fpu issue, operand selection, handshakes
    always_comb begin
        op_state    = 1'b0;
        fpu_ctl.op  = wlsc_pkg::FOP_MUL;
        fpu_a       = 64'd0;
        fpu_b       = 64'd0;
        unique case (r_state)
            wlsc_pkg::ST_BOUND_MUL1: begin
                op_state = 1'b1;
                fpu_a    = r_step;
                fpu_b    = r_cfg[wlsc_pkg::REG_DEC_TOL];
            end
            wlsc_pkg::ST_BOUND_MUL2: begin
                op_state = 1'b1;
                fpu_a    = r_tmp;
                fpu_b    = r_start_slope;
            end
            wlsc_pkg::ST_BOUND_ADD: begin
                op_state   = 1'b1;
                fpu_ctl.op = wlsc_pkg::FOP_ADD;
                fpu_a      = r_start_energy;
                fpu_b      = r_tmp;
            end
            wlsc_pkg::ST_CURV_MUL: begin
                op_state = 1'b1;
                fpu_a    = r_cfg[wlsc_pkg::REG_CURV];
                fpu_b    = r_start_slope;
            end
            wlsc_pkg::ST_STEP_MUL: begin
                op_state = 1'b1;
                fpu_a    = r_step;
                fpu_b    = r_grow_sel ? r_cfg[wlsc_pkg::REG_GROW]
                                      : r_cfg[wlsc_pkg::REG_SHRINK];
            end
            default: ;
        endcase
        fpu_ctl.start = op_state && !r_issued;
        i_req.ready   = (r_state == wlsc_pkg::ST_IDLE);
        o_rsp.valid   = r_out_valid;
        o_rsp.status  = r_out_status;
        o_rsp.step    = r_out_step;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= wlsc_pkg::ST_IDLE;
            r_phase        <= wlsc_pkg::PH_IDLE;
            r_issued       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_start_energy <= 64'd0;
            r_start_slope  <= 64'd0;
            r_step         <= 64'd0;
        end else begin
            r_state <= n_state;
            if (fpu_stat.done) begin
                r_issued <= 1'b0;
            end else if (fpu_ctl.start) begin
                r_issued <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                wlsc_pkg::ST_IDLE: begin
                    if (in_fire && !i_req.req_type) begin
                        r_start_energy <= i_req.energy;
                        r_start_slope  <= i_req.slope;
                        r_step         <= wlsc_pkg::FP_ONE;
                    end
                end
                wlsc_pkg::ST_CURVATURE: begin
                    if (!curv_grow && !curv_shrink) r_phase <= wlsc_pkg::PH_ACCEPT;
                end
                wlsc_pkg::ST_STEP_MUL: begin
                    if (fpu_stat.done) r_step <= fpu_res;
                end
                wlsc_pkg::ST_CHECK: begin
                    r_phase <= check_fail ? wlsc_pkg::PH_FAIL : wlsc_pkg::PH_SEARCH;
                end
                default: ;
            endcase
        end
    end

    // item and intermediate payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req_type <= i_req.req_type;
            r_energy   <= i_req.energy;
            r_slope    <= i_req.slope;
            r_status   <= (r_phase == wlsc_pkg::PH_ACCEPT) ? wlsc_pkg::STATUS_DONE
                                                           : wlsc_pkg::STATUS_FAILED;
        end
        if (fpu_stat.done) r_tmp <= fpu_res;
        if (r_state == wlsc_pkg::ST_DECREASE) r_grow_sel <= 1'b0;
        if (r_state == wlsc_pkg::ST_CURVATURE) begin
            r_grow_sel <= curv_grow;
            if (!curv_grow && !curv_shrink) r_status <= wlsc_pkg::STATUS_DONE;
        end
        if (r_state == wlsc_pkg::ST_CHECK) begin
            r_status <= check_fail ? wlsc_pkg::STATUS_FAILED : wlsc_pkg::STATUS_TRY;
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_step   <= r_step;
        end
    end

    // checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_ctl.start |-> !fpu_stat.busy)
        else $error("fpu issued while busy");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != wlsc_pkg::ST_IDLE))
        else $error("accepted item did not start work");

    a_try_searching: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == wlsc_pkg::ST_OUTPUT) && (r_status == wlsc_pkg::STATUS_TRY) &&
         !r_req_type) || ((r_state == wlsc_pkg::ST_OUTPUT) &&
         (r_status == wlsc_pkg::STATUS_TRY)) |-> (r_phase == wlsc_pkg::PH_SEARCH))
        else $error("try status outside a search");

    a_done_in_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_stat.done |-> ((r_state == wlsc_pkg::ST_BOUND_MUL1) ||
                           (r_state == wlsc_pkg::ST_BOUND_MUL2) ||
                           (r_state == wlsc_pkg::ST_BOUND_ADD) ||
                           (r_state == wlsc_pkg::ST_CURV_MUL) ||
                           (r_state == wlsc_pkg::ST_STEP_MUL)))
        else $error("fpu result outside an operation state");

endmodule
`default_nettype wire

FILE: sv/wlsc_fpu.sv
// shared binary64 multiply and add unit, multi-cycle, round to nearest even
`timescale 1ns / 1ps
`default_nettype none
module wlsc_fpu (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire wlsc_pkg::t_fpu_ctl  i_ctl,
    input  wire logic [63:0]         i_a,
    input  wire logic [63:0]         i_b,
    output wlsc_pkg::t_fpu_stat      o_stat,
    output logic [63:0]              o_result
);

    localparam int MW  = wlsc_pkg::MAN_W;
    localparam int LZW = wlsc_pkg::LZ_W;
    localparam int EW  = wlsc_pkg::EXP_W;

    wlsc_pkg::t_fpu_state r_state, n_state;
    wlsc_pkg::t_fpu_op    r_op;
    logic [63:0]          r_a, r_b;
    logic                 r_sign;
    logic signed [EW-1:0] r_exp;
    logic [MW-1:0]        r_man;
    logic [1:0]           r_cnt;
    logic [63:0]          r_result;
    logic                 r_done;

    // leading zero count of the working significand
    function automatic logic [LZW-1:0] lead_zeros(input logic [MW-1:0] m);
        logic [LZW-1:0] n;
        n = '0;
        for (int i = 0; i < MW; i++) begin
            if (m[i]) n = LZW'(MW - 1 - i);
        end
        return n;
    endfunction

    function automatic logic [10:0] eff_exp(input logic [63:0] x);
        return (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    endfunction

    function automatic logic [52:0] full_man(input logic [63:0] x);
        return {(x[62:52] != 11'd0), x[51:0]};
    endfunction

    // operand classification and special results at issue
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        spec_hit;
    logic [63:0] spec_val;
    logic        a_ge;
    logic [63:0] big, sml;

    always_comb begin
        a_nan  = wlsc_pkg::fp_is_nan(i_a);
        b_nan  = wlsc_pkg::fp_is_nan(i_b);
        a_inf  = (i_a[62:0] == {11'h7FF, 52'd0});
        b_inf  = (i_b[62:0] == {11'h7FF, 52'd0});
        a_zero = (i_a[62:0] == 63'd0);
        b_zero = (i_b[62:0] == 63'd0);
        spec_hit = 1'b1;
        spec_val = wlsc_pkg::FP_QNAN;
        priority if (a_nan) begin
            spec_val = i_a | wlsc_pkg::FP_QBIT;
        end else if (b_nan) begin
            spec_val = i_b | wlsc_pkg::FP_QBIT;
        end else if (i_ctl.op == wlsc_pkg::FOP_MUL) begin
            priority if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                spec_val = wlsc_pkg::FP_QNAN;
            end else if (a_inf || b_inf) begin
                spec_val = {i_a[63] ^ i_b[63], 11'h7FF, 52'd0};
            end else if (a_zero || b_zero) begin
                spec_val = {i_a[63] ^ i_b[63], 63'd0};
            end else begin
                spec_hit = 1'b0;
            end
        end else begin
            priority if (a_inf && b_inf && (i_a[63] != i_b[63])) begin
                spec_val = wlsc_pkg::FP_QNAN;
            end else if (a_inf) begin
                spec_val = i_a;
            end else if (b_inf) begin
                spec_val = i_b;
            end else if (a_zero && b_zero) begin
                spec_val = {i_a[63] & i_b[63], 63'd0};
            end else begin
                spec_hit = 1'b0;
            end
        end
        a_ge = (i_a[62:0] >= i_b[62:0]);
        big  = a_ge ? i_a : i_b;
        sml  = a_ge ? i_b : i_a;
    end

    // one 27x27 partial product per cycle
    logic [26:0]   pp_a, pp_b;
    logic [53:0]   pp;
    logic [MW-1:0] pp_ext;
    logic [52:0]   ma, mb;

    always_comb begin
        ma = full_man(r_a);
        mb = full_man(r_b);
        pp_a = ma[26:0];
        pp_b = mb[26:0];
        unique case (r_cnt)
            2'd0: begin
                pp_a = ma[26:0];
                pp_b = mb[26:0];
            end
            2'd1: begin
                pp_a = ma[26:0];
                pp_b = {1'b0, mb[52:27]};
            end
            2'd2: begin
                pp_a = {1'b0, ma[52:27]};
                pp_b = mb[26:0];
            end
            2'd3: begin
                pp_a = {1'b0, ma[52:27]};
                pp_b = {1'b0, mb[52:27]};
            end
        endcase
        pp = pp_a * pp_b;
        unique case (r_cnt)
            2'd0:    pp_ext = {54'd0, pp} << 2;
            2'd1:    pp_ext = {54'd0, pp} << 29;
            2'd2:    pp_ext = {54'd0, pp} << 29;
            default: pp_ext = {54'd0, pp} << 56;
        endcase
    end

    // alignment and add of the smaller operand
    logic [10:0]   dexp;
    logic [MW-1:0] add_big, add_sml, add_shift, add_mask, add_sum;
    logic          add_sticky;

    always_comb begin
        dexp      = eff_exp(r_a) - eff_exp(r_b);
        add_big   = {1'b0, full_man(r_a), 54'd0};
        add_sml   = {1'b0, full_man(r_b), 54'd0};
        add_shift = add_sml >> dexp;
        add_mask  = ~({MW{1'b1}} << dexp);
        add_sticky = |(add_sml & add_mask);
        if (r_a[63] != r_b[63]) begin
            add_sum = add_big - (add_shift | {{(MW-1){1'b0}}, add_sticky});
        end else begin
            add_sum = add_big + (add_shift | {{(MW-1){1'b0}}, add_sticky});
        end
    end

    // normalisation
    logic [LZW-1:0] lz;
    assign lz = lead_zeros(r_man);

    // denormal shift, rounding and packing
    logic [EW-1:0] rsh;
    logic [MW-1:0] rm;
    logic          rst_in, rsticky, rinc;
    logic [12:0]   ebase;
    logic [53:0]   m54;
    logic [64:0]   tot;
    logic [63:0]   round_val;

    always_comb begin
        rsh    = EW'(14'sd1 - r_exp);
        rm     = r_man;
        rst_in = 1'b0;
        ebase  = 13'(r_exp - 14'sd1);
        if (r_exp <= 14'sd0) begin
            ebase = 13'd0;
            if (rsh >= EW'(MW + 2)) begin
                rm     = '0;
                rst_in = |r_man;
            end else begin
                rm     = r_man >> rsh[LZW-1:0];
                rst_in = |(r_man & ~({MW{1'b1}} << rsh[LZW-1:0]));
            end
        end
        rsticky = rst_in | (|rm[53:0]);
        rinc    = rm[54] & (rsticky | rm[55]);
        m54     = {1'b0, rm[107:55]} + {53'd0, rinc};
        tot     = {ebase, 52'd0} + {11'd0, m54};
        if (tot[64:52] >= 13'd2047) begin
            round_val = {r_sign, 11'h7FF, 52'd0};
        end else begin
            round_val = {r_sign, tot[62:0]};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wlsc_pkg::FS_IDLE: begin
                if (i_ctl.start && !spec_hit) begin
                    n_state = (i_ctl.op == wlsc_pkg::FOP_MUL) ? wlsc_pkg::FS_MUL
                                                               : wlsc_pkg::FS_ADD;
                end
            end
            wlsc_pkg::FS_MUL: begin
                if (r_cnt == 2'd3) n_state = wlsc_pkg::FS_NORM;
            end
            wlsc_pkg::FS_ADD:  n_state = wlsc_pkg::FS_NORM;
            wlsc_pkg::FS_NORM: begin
                n_state = (r_man == '0) ? wlsc_pkg::FS_IDLE : wlsc_pkg::FS_ROUND;
            end
            wlsc_pkg::FS_ROUND: n_state = wlsc_pkg::FS_IDLE;
            default:            n_state = wlsc_pkg::FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stat.busy = (r_state != wlsc_pkg::FS_IDLE);
        o_stat.done = r_done;
        o_result    = r_result;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wlsc_pkg::FS_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                wlsc_pkg::FS_IDLE: begin
                    r_cnt <= 2'd0;
                    if (i_ctl.start && spec_hit) r_done <= 1'b1;
                end
                wlsc_pkg::FS_MUL:   r_cnt <= r_cnt + 2'd1;
                wlsc_pkg::FS_NORM:  r_done <= (r_man == '0);
                wlsc_pkg::FS_ROUND: r_done <= 1'b1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            wlsc_pkg::FS_IDLE: begin
                if (i_ctl.start) begin
                    r_op     <= i_ctl.op;
                    r_result <= spec_val;
                    r_man    <= '0;
                    if (i_ctl.op == wlsc_pkg::FOP_MUL) begin
                        r_a    <= i_a;
                        r_b    <= i_b;
                        r_sign <= i_a[63] ^ i_b[63];
                        r_exp  <= $signed({3'd0, eff_exp(i_a)}) + $signed({3'd0, eff_exp(i_b)})
                                  - 14'sd1022;
                    end else begin
                        r_a    <= big;
                        r_b    <= sml;
                        r_sign <= big[63];
                        r_exp  <= $signed({3'd0, eff_exp(big)}) + 14'sd1;
                    end
                end
            end
            wlsc_pkg::FS_MUL: r_man <= r_man + pp_ext;
            wlsc_pkg::FS_ADD: r_man <= add_sum;
            wlsc_pkg::FS_NORM: begin
                r_man <= r_man << lz;
                r_exp <= r_exp - $signed({7'd0, lz});
                // exact cancellation gives plus zero
                if (r_man == '0) begin
                    r_result <= {(r_op == wlsc_pkg::FOP_MUL) ? r_sign : 1'b0, 63'd0};
                end
            end
            wlsc_pkg::FS_ROUND: r_result <= round_val;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: tb/sv/wolfe_line_search_controller_top_test.sv
// testbench of the wolfe line search controller: directed table, then random searches
`timescale 1ns / 1ps
`default_nettype none
module wolfe_line_search_controller_top_test;

    typedef struct {
        bit          is_trial;
        logic [63:0] energy;
        logic [63:0] slope;
        bit          typed;
        logic [1:0]  status;
        logic [63:0] step;
    } t_row;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] step;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [wlsc_pkg::ADDR_W-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    wlsc_req_if req_ch ();
    wlsc_rsp_if rsp_ch ();

    wolfe_line_search_controller_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the registers and of the search state
    logic [63:0]      cfg [wlsc_pkg::REG_COUNT];
    logic [63:0]      sh_start_slope, sh_start_energy, sh_step;
    wlsc_pkg::t_phase sh_phase;

    t_outcome outcome_q [$];
    int       n_errors = 0;
    int       burst_left = 0;
    bit       all_sent = 1'b0;
    t_row     dir_tab [$];

    // --------------------------------------------------------------
    // binary64 helpers
    function automatic bit is_nan64(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != 0);
    endfunction

    // ordered a < b, false on nan, +0 equals -0
    function automatic bit less64(input logic [63:0] a, input logic [63:0] b);
        if (is_nan64(a) || is_nan64(b)) return 1'b0;
        if (a[62:0] == 0 && b[62:0] == 0) return 1'b0;
        if (a[63] != b[63]) return a[63];
        return a[63] ? (a[62:0] > b[62:0]) : (a[62:0] < b[62:0]);
    endfunction

    function automatic logic [63:0] mul64(input logic [63:0] a, input logic [63:0] b);
        return $realtobits($bitstoreal(a) * $bitstoreal(b));
    endfunction

    function automatic logic [63:0] add64(input logic [63:0] a, input logic [63:0] b);
        return $realtobits($bitstoreal(a) + $bitstoreal(b));
    endfunction

    // range and slope-sign test after a step change
    function automatic logic [1:0] settle_step();
        if (less64(wlsc_pkg::FP_ZERO, sh_start_slope)
                || less64(sh_step, cfg[wlsc_pkg::REG_MIN_STEP])
                || less64(cfg[wlsc_pkg::REG_MAX_STEP], sh_step)) begin
            sh_phase = wlsc_pkg::PH_FAIL;
            return wlsc_pkg::STATUS_FAILED;
        end
        sh_phase = wlsc_pkg::PH_SEARCH;
        return wlsc_pkg::STATUS_TRY;
    endfunction

    // next step decision for one transfer
    function automatic t_outcome decide_step(input bit is_trial, input logic [63:0] e,
                                             input logic [63:0] g);
        t_outcome    r;
        logic [63:0] bound, neg_c;
        if (!is_trial) begin
            sh_start_energy = e;
            sh_start_slope  = g;
            sh_step         = wlsc_pkg::FP_ONE;
            r.status        = settle_step();
        end else if (sh_phase != wlsc_pkg::PH_SEARCH) begin
            r.status = (sh_phase == wlsc_pkg::PH_ACCEPT) ? wlsc_pkg::STATUS_DONE
                                                         : wlsc_pkg::STATUS_FAILED;
        end else begin
            bound = add64(sh_start_energy,
                          mul64(mul64(sh_step, cfg[wlsc_pkg::REG_DEC_TOL]), sh_start_slope));
            neg_c = {~cfg[wlsc_pkg::REG_CURV][63], cfg[wlsc_pkg::REG_CURV][62:0]};
            if (e[62:52] == 11'h7FF || less64(bound, e)) begin
                sh_step  = mul64(sh_step, cfg[wlsc_pkg::REG_SHRINK]);
                r.status = settle_step();
            end else if (less64(g, mul64(cfg[wlsc_pkg::REG_CURV], sh_start_slope))) begin
                sh_step  = mul64(sh_step, cfg[wlsc_pkg::REG_GROW]);
                r.status = settle_step();
            end else if (less64(mul64(neg_c, sh_start_slope), g)) begin
                sh_step  = mul64(sh_step, cfg[wlsc_pkg::REG_SHRINK]);
                r.status = settle_step();
            end else begin
                sh_phase = wlsc_pkg::PH_ACCEPT;
                r.status = wlsc_pkg::STATUS_DONE;
            end
        end
        r.step = sh_step;
        return r;
    endfunction

    // --------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch %s got %h want %h", $realtime, what, got, want);
        n_errors++;
    endtask

    // register write: setup then access phase
    task automatic write_reg(input logic [wlsc_pkg::IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel   = 1'b1;
        pwrite = 1'b1;
        paddr  = wlsc_pkg::ADDR_W'(idx) << 3;
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        cfg[idx] = val;
    endtask

    task automatic program_all(input logic [63:0] mn, input logic [63:0] mx,
                               input logic [63:0] dt, input logic [63:0] cv,
                               input logic [63:0] gr, input logic [63:0] sr);
        // block must be quiet first
        wait (outcome_q.size() == 0);
        repeat (60) @(posedge i_clk);
        write_reg(wlsc_pkg::REG_MIN_STEP, mn);
        write_reg(wlsc_pkg::REG_MAX_STEP, mx);
        write_reg(wlsc_pkg::REG_DEC_TOL, dt);
        write_reg(wlsc_pkg::REG_CURV, cv);
        write_reg(wlsc_pkg::REG_GROW, gr);
        write_reg(wlsc_pkg::REG_SHRINK, sr);
    endtask

    // one request transfer, with burst gaps
    task automatic send_req(input t_row row);
        t_outcome o;
        @(negedge i_clk);
        if (burst_left == 0) begin
            req_ch.valid = 1'b0;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        req_ch.valid    = 1'b1;
        req_ch.req_type = row.is_trial;
        req_ch.energy   = row.energy;
        req_ch.slope    = row.slope;
        do @(posedge i_clk); while (!req_ch.ready);
        o = decide_step(row.is_trial, row.energy, row.slope);
        if (row.typed) begin
            o.status = row.status;
            o.step   = row.step;
        end
        outcome_q.push_back(o);
        burst_left--;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        burst_left = 0;
    endtask

    function automatic logic [63:0] rand_bits();
        return {$urandom, $urandom};
    endfunction

    // value near base with a random offset of at most spread either way
    function automatic logic [63:0] near(input real base, input real spread);
        real f;
        f = ($itor($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
        return $realtobits(base + spread * f);
    endfunction

    function automatic t_row plain(input bit tr, input logic [63:0] e, input logic [63:0] g);
        t_row r;
        r = '{tr, e, g, 1'b0, wlsc_pkg::STATUS_TRY, wlsc_pkg::FP_ZERO};
        return r;
    endfunction

    function automatic t_row fixed(input bit tr, input logic [63:0] e, input logic [63:0] g,
                                   input logic [1:0] st, input logic [63:0] sp);
        t_row r;
        r = '{tr, e, g, 1'b1, st, sp};
        return r;
    endfunction

    // well-formed searches with random content, some noise
    task automatic random_part(input int n_items);
        int   k, n_trials;
        real  e0, g0, sc;
        t_row row;
        k = 0;
        while (k < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                sc = 10.0 ** $urandom_range(0, 6);
                e0 = $bitstoreal(near(0.0, sc));
                g0 = -$bitstoreal(near(sc, sc));
                if ($urandom_range(0, 15) == 0) g0 = -g0;
                send_req(plain(1'b0, $realtobits(e0), $realtobits(g0)));
                n_trials = $urandom_range(1, 8);
                for (int t = 0; t < n_trials; t++) begin
                    row = plain(1'b1, near(e0, 2.0 * sc), near(0.0, 2.0 * (g0 < 0 ? -g0 : g0)));
                    case ($urandom_range(0, 19))
                        0: row.energy = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'h7FF, 52'd0};
                        1: row.energy = {1'b0, 11'h7FF, 20'd0, $urandom | 32'd1};
                        2: row.slope  = rand_bits();
                        default: ;
                    endcase
                    send_req(row);
                end
                k += n_trials + 1;
            end else begin
                send_req(plain($urandom_range(0, 1), rand_bits(), rand_bits()));
                k++;
            end
            if ($urandom_range(0, 7) == 0) end_burst();
        end
        end_burst();
    endtask

    // --------------------------------------------------------------
    // receiver stall pattern: quiet spells and stall spells
    initial begin
        int mode;
        rsp_ch.ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(16, 96)) begin
                @(negedge i_clk);
                case (mode)
                    0: rsp_ch.ready = 1'b1;
                    1: rsp_ch.ready = ($urandom_range(0, 2) != 0);
                    default: rsp_ch.ready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // result transfers against the expectation store
    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("unexpected result", {62'd0, rsp_ch.status}, 64'd0);
            end else begin
                w = outcome_q.pop_front();
                if (rsp_ch.status !== w.status)
                    report_mismatch("status", {62'd0, rsp_ch.status}, {62'd0, w.status});
                if (is_nan64(w.step) ? !is_nan64(rsp_ch.step) : (rsp_ch.step !== w.step))
                    report_mismatch("step", rsp_ch.step, w.step);
            end
        end
    end

    // run limit
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        req_ch.valid    = 1'b0;
        req_ch.req_type = 1'b0;
        req_ch.energy   = '0;
        req_ch.slope    = '0;
        for (int i = 0; i < wlsc_pkg::REG_COUNT; i++) cfg[i] = wlsc_pkg::FP_ZERO;
        sh_start_slope  = wlsc_pkg::FP_ZERO;
        sh_start_energy = wlsc_pkg::FP_ZERO;
        sh_step         = wlsc_pkg::FP_ZERO;
        sh_phase        = wlsc_pkg::PH_IDLE;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // registers still zero: max step 0 fails every start
        send_req(fixed(1'b1, wlsc_pkg::FP_ZERO, wlsc_pkg::FP_ZERO,
                       wlsc_pkg::STATUS_FAILED, wlsc_pkg::FP_ZERO));
        send_req(fixed(1'b0, wlsc_pkg::FP_ZERO, 64'hBFF0_0000_0000_0000,
                       wlsc_pkg::STATUS_FAILED, wlsc_pkg::FP_ONE));
        send_req(fixed(1'b1, 64'h4024_0000_0000_0000, wlsc_pkg::FP_ZERO,
                       wlsc_pkg::STATUS_FAILED, wlsc_pkg::FP_ONE));
        end_burst();

        program_all($realtobits(1e-20), $realtobits(1e20), $realtobits(1e-4),
                    $realtobits(0.9), $realtobits(2.0), $realtobits(0.5));
        dir_tab = '{
            plain(1'b0, $realtobits(10.0), $realtobits(-1.0)),
            plain(1'b1, 64'h7FF0_0000_0000_0000, wlsc_pkg::FP_ZERO),  // infinite energy
            plain(1'b1, 64'h7FF8_0000_0000_0000, wlsc_pkg::FP_ZERO),  // nan energy
            plain(1'b1, $realtobits(20.0), wlsc_pkg::FP_ZERO),        // too little decrease
            plain(1'b1, $realtobits(9.0), $realtobits(-5.0)),         // steep: grow
            plain(1'b1, $realtobits(9.0), $realtobits(5.0)),          // uphill: shrink
            plain(1'b1, $realtobits(9.0), $realtobits(-0.1)),         // accepted
            plain(1'b1, wlsc_pkg::FP_ZERO, wlsc_pkg::FP_ZERO),        // trial after accept
            fixed(1'b0, wlsc_pkg::FP_ZERO, wlsc_pkg::FP_ONE, wlsc_pkg::STATUS_FAILED,
                  wlsc_pkg::FP_ONE),
            plain(1'b1, wlsc_pkg::FP_ZERO, wlsc_pkg::FP_ZERO),        // trial after fail
            plain(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, wlsc_pkg::FP_ZERO),
            plain(1'b1, 64'hFFEF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000),
            plain(1'b0, wlsc_pkg::FP_ZERO, 64'hFFFF_FFFF_FFFF_FFFF),  // nan start slope
            plain(1'b1, wlsc_pkg::FP_ZERO, wlsc_pkg::FP_ZERO),
            plain(1'b0, wlsc_pkg::FP_ZERO, 64'hBFF0_0000_0000_0000),
            plain(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF)
        };
        foreach (dir_tab[i]) send_req(dir_tab[i]);
        end_burst();

        // random phases over several register settings
        random_part(220);
        program_all(wlsc_pkg::FP_ZERO, 64'h7FF0_0000_0000_0000, wlsc_pkg::FP_ZERO,
                    wlsc_pkg::FP_ZERO, wlsc_pkg::FP_ZERO, wlsc_pkg::FP_ZERO);
        random_part(160);
        program_all(64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF, wlsc_pkg::FP_ONE,
                    wlsc_pkg::FP_ONE, $realtobits(1e300), $realtobits(1e-300));
        random_part(200);
        program_all(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        random_part(120);
        program_all(wlsc_pkg::FP_ONE, wlsc_pkg::FP_ONE, $realtobits(0.3), $realtobits(0.5),
                    $realtobits(1.5), $realtobits(0.75));
        random_part(160);
        program_all(rand_bits(), rand_bits(), rand_bits(), rand_bits(), rand_bits(),
                    rand_bits());
        random_part(120);
        program_all($realtobits(1e-6), $realtobits(64.0), $realtobits(1e-4),
                    $realtobits(0.1), $realtobits(3.0), $realtobits(0.25));
        random_part(250);

        wait (outcome_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
